// File: rtl/jlsp_pkg.sv
// jlsp_pkg: shared types, constants and helpers for the jerk-limited speed profile.
// Used by jlsp_divsqrt, the top level and jlsp_check; no dependencies of its own.
package jlsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SEGMENTS  = 4;
  localparam int SEG_W     = $clog2(SEGMENTS);
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int TICK_W    = 16;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // Input kinds carried on s_tuser
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JERK_ACCEL = 3'd0,
    CFG_ACCEL_LIM  = 3'd1,
    CFG_JERK_DECEL = 3'd2,
    CFG_DECEL_LIM  = 3'd3,
    CFG_TICK_PER   = 3'd4
  } cfg_idx_t;

  // Result status codes carried on m_tuser
  typedef enum logic [2:0] {
    STAT_TICK    = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_REDUCED = 3'd2,
    STAT_BUSY    = 3'd3,
    STAT_SAME    = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TK_TIME,
    ST_TK_SEG,
    ST_TK_ACC,
    ST_TK_DV1,
    ST_TK_LO,
    ST_TK_HI,
    ST_TK_SPD,
    ST_P_DVJ,
    ST_P_AA,
    ST_P_CMP,
    ST_P_SQRT,
    ST_P_PK,
    ST_P_TR,
    ST_P_VADD,
    ST_P_MID,
    ST_P_WRITE,
    ST_DONE
  } state_t;

  // Request to the divide / square-root unit
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } ds_req_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Saturating time add; the addend is clamped to the time range first
  function automatic logic [31:0] tadd(input logic [31:0] a, input logic [63:0] b);
    logic [31:0] bc;
    logic [32:0] s;
    bc = (b > {32'd0, TIME_MAX}) ? TIME_MAX : b[31:0];
    s  = {1'b0, a} + {1'b0, bc};
    return s[32] ? TIME_MAX : s[31:0];
  endfunction

endpackage

// File: rtl/jlsp_mul.sv
// jlsp_mul: shared signed 33x33 multiplier with registered product.
// Depends on nothing; operands are driven by the sequencer in the top level.
module jlsp_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  // product is registered, valid in the cycle after the operands
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/jlsp_divsqrt.sv
// jlsp_divsqrt: iterative unsigned divider (one quotient bit per cycle) and
// integer square root (one root bit per cycle). Uses jlsp_pkg::ds_req_t.
module jlsp_divsqrt (
  input  logic             clk,
  input  logic             rst,
  input  jlsp_pkg::ds_req_t req,
  input  logic [63:0]      dividend,
  input  logic [31:0]      divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      result
);

  logic        sqrt_mode;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dvs;
  logic [63:0] sx;
  logic [63:0] sr;
  logic [63:0] sbit;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        fits;
  logic [63:0] trial;
  logic        sfit;

  // one restoring step and one root step
  always_comb begin
    rem_sh  = {rem, quo[63]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = rem_sh >= {1'b0, dvs};
    trial   = sr + sbit;
    sfit    = sx >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy      <= 1'b1;
        sqrt_mode <= req.sqrt_mode;
        cnt       <= req.sqrt_mode ? 6'd31 : 6'd63;
        rem       <= '0;
        quo       <= dividend;
        dvs       <= divisor;
        sx        <= dividend;
        sr        <= '0;
        sbit      <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (sqrt_mode) begin
          if (sfit) begin
            sx <= sx - trial;
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
        end else begin
          quo <= {quo[62:0], fits};
          rem <= fits ? rem_sub[31:0] : rem_sh[31:0];
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign result = sqrt_mode ? sr : quo;

endmodule

// File: rtl/jerk_limited_speed_profile.sv
// jerk_limited_speed_profile: top level, sequencer and profile state.
// Uses jlsp_pkg, jlsp_mul (shared multiplier) and jlsp_divsqrt (divide / root).
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------
//  s_       | in  | s_tvalid/tready  | tdata: speed_req[31:0]; tuser: operation
//  m_       | out | m_tvalid/tready  | tdata: speed, accel, jerk, segment; tuser: status
//  cfg_     | in  | cfg_we           | cfg_index, cfg_data
//
// A tick runs time update, segment select, acceleration, speed terms and speed sum before
// its result (only the time update without a plan); an ignored target goes straight to the
// result. A planned target runs three divides (full curve) or a root and two divides (reduced).
// s_tready is high only while idle. A stalled result holds in the output register
// and the block waits in its final state until it is taken.
// rst is synchronous; it restores the register defaults and clears the plan.
module jerk_limited_speed_profile (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // [31:0] speed_req
  input  logic          s_tuser,   // [0] operation
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // [31:0] speed_out, [63:32] accel_out,
                                   // [95:64] jerk_out, [97:96] segment_out, rest zero
  output logic [2:0]    m_tuser,   // [2:0] plan_status
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_data
);

  localparam int FB = jlsp_pkg::FRAC_BITS;

  jlsp_pkg::state_t  state, state_next;
  jlsp_pkg::status_t res_status;

  // configuration
  logic [23:0] jerk_acc, acc_lim, jerk_dec, dec_lim;
  logic [15:0] tick_per;

  // profile state
  logic signed [31:0] seg_speed [jlsp_pkg::SEGMENTS];
  logic signed [31:0] seg_accel [jlsp_pkg::SEGMENTS];
  logic signed [31:0] seg_jerk  [jlsp_pkg::SEGMENTS];
  logic [31:0]        seg_start [jlsp_pkg::SEGMENTS];
  logic [31:0]        seg_end   [jlsp_pkg::SEGMENTS];
  logic [jlsp_pkg::SEG_W-1:0] active;
  logic               plan_valid;
  logic [31:0]        elapsed;
  logic signed [31:0] speed_now, accel_now, last_target;

  // working registers
  logic signed [31:0] tgt, res_jerk;
  logic [31:0]        tk_t;
  logic signed [31:0] tk_j, tk_a, tk_v;
  logic signed [63:0] tk_da, tk_dv1, tk_dv2;
  logic [47:0]        tk_mag;
  logic [55:0]        tk_lo;
  logic               p_up, p_full;
  logic [31:0]        p_dv;
  logic [23:0]        p_a, p_j;
  logic [27:0]        p_pk;
  logic [63:0]        p_dvj, p_pp, p_tr, p_vadd, p_tmid;
  logic               issued;

  // shared units
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  jlsp_pkg::ds_req_t  ds_req;
  logic [63:0]        ds_dividend, ds_result;
  logic [31:0]        ds_divisor;
  logic               ds_busy, ds_done;

  jlsp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  jlsp_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .req      (ds_req),
    .dividend (ds_dividend),
    .divisor  (ds_divisor),
    .busy     (ds_busy),
    .done     (ds_done),
    .result   (ds_result)
  );

  assign s_tready = (state == jlsp_pkg::ST_IDLE);

  // tick arithmetic
  logic [31:0]        t_calc;
  logic signed [63:0] da_c, dv1_c, dv2_c, pm, sv;
  logic [63:0]        mag_c;
  logic [79:0]        prod_c;
  logic signed [31:0] acc_c, spd_c;
  always_comb begin
    t_calc = (elapsed >= seg_start[active]) ? elapsed - seg_start[active] : 32'd0;
    da_c   = $signed(mul_p[63:0]) >>> FB;
    mag_c  = da_c[63] ? 64'(-da_c) : 64'(da_c);
    acc_c  = jlsp_pkg::sat32({{34{tk_a[31]}}, tk_a} + {{2{da_c[63]}}, da_c});
    dv1_c  = $signed(mul_p[63:0]) >>> FB;
    prod_c = {24'd0, tk_lo} + {mul_p[55:0], 24'd0};
    pm     = $signed(prod_c[63:0]);
    sv     = tk_da[63] ? -pm : pm;
    if (prod_c > 80'h2000_0000_0000_0000) begin
      dv2_c = tk_da[63] ? -64'sh1000_0000_0000_0000 : 64'sh1000_0000_0000_0000;
    end else begin
      dv2_c = sv >>> (FB + 1);
    end
    spd_c = jlsp_pkg::sat32({{34{tk_v[31]}}, tk_v} + {{2{tk_dv1[63]}}, tk_dv1}
                            + {{2{tk_dv2[63]}}, tk_dv2});
  end

  // plan setup arithmetic
  logic [32:0] d_c, nd_c;
  logic        up_c, full_c;
  logic [31:0] dv_c;
  logic [23:0] a_c, j_c;
  logic [63:0] mid_c;
  always_comb begin
    d_c    = {tgt[31], tgt} - {speed_now[31], speed_now};
    nd_c   = 33'd0 - d_c;
    up_c   = !d_c[32] && (d_c != 33'd0);
    dv_c   = up_c ? d_c[31:0] : nd_c[31:0];
    a_c    = up_c ? acc_lim : dec_lim;
    j_c    = up_c ? jerk_acc : jerk_dec;
    if (a_c == 24'd0) a_c = 24'd1;
    if (j_c == 24'd0) j_c = 24'd1;
    full_c = p_dvj >= mul_p[63:0];
    mid_c  = {32'd0, p_dv} - (p_vadd << 1);
  end

  // plan write-back values
  logic signed [65:0] vadd_s, s1v, s2v;
  logic signed [31:0] jpos, sgnj, nsgnj, pk32, sgnpk;
  logic [31:0]        e0, e1, e2;
  always_comb begin
    vadd_s = $signed({2'b00, p_vadd});
    s1v    = p_up ? {{34{speed_now[31]}}, speed_now} + vadd_s
                  : {{34{speed_now[31]}}, speed_now} - vadd_s;
    s2v    = p_up ? {{34{tgt[31]}}, tgt} - vadd_s : {{34{tgt[31]}}, tgt} + vadd_s;
    jpos   = $signed({8'd0, p_j});
    sgnj   = p_up ? jpos : -jpos;
    nsgnj  = p_up ? -jpos : jpos;
    pk32   = $signed({4'd0, p_pk});
    sgnpk  = p_up ? pk32 : -pk32;
    e0     = jlsp_pkg::tadd(elapsed, p_tr);
    e1     = jlsp_pkg::tadd(e0, p_full ? p_tmid : p_tr);
    e2     = jlsp_pkg::tadd(e1, p_tr);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      jlsp_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          priority if (s_tuser == jlsp_pkg::OP_TICK) state_next = jlsp_pkg::ST_TK_TIME;
          else if ($signed(s_tdata) == last_target)  state_next = jlsp_pkg::ST_DONE;
          else if (accel_now != 32'sd0)              state_next = jlsp_pkg::ST_DONE;
          else                                       state_next = jlsp_pkg::ST_P_DVJ;
        end
      end
      jlsp_pkg::ST_TK_TIME: state_next = plan_valid ? jlsp_pkg::ST_TK_SEG : jlsp_pkg::ST_DONE;
      jlsp_pkg::ST_TK_SEG:  state_next = jlsp_pkg::ST_TK_ACC;
      jlsp_pkg::ST_TK_ACC:  state_next = jlsp_pkg::ST_TK_DV1;
      jlsp_pkg::ST_TK_DV1:  state_next = jlsp_pkg::ST_TK_LO;
      jlsp_pkg::ST_TK_LO:   state_next = jlsp_pkg::ST_TK_HI;
      jlsp_pkg::ST_TK_HI:   state_next = jlsp_pkg::ST_TK_SPD;
      jlsp_pkg::ST_TK_SPD:  state_next = jlsp_pkg::ST_DONE;
      jlsp_pkg::ST_P_DVJ:   state_next = jlsp_pkg::ST_P_AA;
      jlsp_pkg::ST_P_AA:    state_next = jlsp_pkg::ST_P_CMP;
      jlsp_pkg::ST_P_CMP:   state_next = full_c ? jlsp_pkg::ST_P_PK : jlsp_pkg::ST_P_SQRT;
      jlsp_pkg::ST_P_SQRT:  if (ds_done) state_next = jlsp_pkg::ST_P_PK;
      jlsp_pkg::ST_P_PK:    state_next = jlsp_pkg::ST_P_TR;
      jlsp_pkg::ST_P_TR:    if (ds_done) state_next = jlsp_pkg::ST_P_VADD;
      jlsp_pkg::ST_P_VADD: begin
        if (ds_done) state_next = p_full ? jlsp_pkg::ST_P_MID : jlsp_pkg::ST_P_WRITE;
      end
      jlsp_pkg::ST_P_MID:   if (ds_done) state_next = jlsp_pkg::ST_P_WRITE;
      jlsp_pkg::ST_P_WRITE: state_next = jlsp_pkg::ST_DONE;
      jlsp_pkg::ST_DONE:    if (!m_tvalid || m_tready) state_next = jlsp_pkg::ST_IDLE;
      default:              state_next = jlsp_pkg::ST_IDLE;
    endcase
  end

  // shared unit operands per state
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    ds_req      = '0;
    ds_dividend = '0;
    ds_divisor  = '0;
    unique case (state)
      jlsp_pkg::ST_TK_SEG: begin
        mul_a = {seg_jerk[active][31], seg_jerk[active]};
        mul_b = {1'b0, t_calc};
      end
      jlsp_pkg::ST_TK_ACC: begin
        mul_a = {tk_a[31], tk_a};
        mul_b = {1'b0, tk_t};
      end
      jlsp_pkg::ST_TK_DV1: begin
        mul_a = {9'd0, tk_mag[23:0]};
        mul_b = {1'b0, tk_t};
      end
      jlsp_pkg::ST_TK_LO: begin
        mul_a = {9'd0, tk_mag[47:24]};
        mul_b = {1'b0, tk_t};
      end
      jlsp_pkg::ST_P_DVJ: begin
        mul_a = {1'b0, dv_c};
        mul_b = {9'd0, j_c};
      end
      jlsp_pkg::ST_P_AA: begin
        mul_a = {9'd0, p_a};
        mul_b = {9'd0, p_a};
      end
      jlsp_pkg::ST_P_PK: begin
        mul_a = {5'd0, p_pk};
        mul_b = {5'd0, p_pk};
      end
      jlsp_pkg::ST_P_SQRT: begin
        ds_req.start     = !issued && !ds_busy;
        ds_req.sqrt_mode = 1'b1;
        ds_dividend      = p_dvj;
      end
      jlsp_pkg::ST_P_TR: begin
        ds_req.start = !issued && !ds_busy;
        ds_dividend  = {36'd0, p_pk} << FB;
        ds_divisor   = {8'd0, p_j};
      end
      jlsp_pkg::ST_P_VADD: begin
        ds_req.start = !issued && !ds_busy;
        ds_dividend  = p_pp;
        ds_divisor   = {7'd0, p_j, 1'b0};
      end
      jlsp_pkg::ST_P_MID: begin
        ds_req.start = !issued && !ds_busy;
        ds_dividend  = mid_c << FB;
        ds_divisor   = {8'd0, p_a};
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= jlsp_pkg::ST_IDLE;
      jerk_acc    <= 24'd65536;
      acc_lim     <= 24'd32768;
      jerk_dec    <= 24'd131072;
      dec_lim     <= 24'd65536;
      tick_per    <= 16'd655;
      for (int k = 0; k < jlsp_pkg::SEGMENTS; k++) begin
        seg_speed[k] <= '0;
        seg_accel[k] <= '0;
        seg_jerk[k]  <= '0;
        seg_start[k] <= '0;
        seg_end[k]   <= '0;
      end
      active      <= '0;
      plan_valid  <= 1'b0;
      elapsed     <= '0;
      speed_now   <= '0;
      accel_now   <= '0;
      last_target <= '0;
      issued      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          jlsp_pkg::CFG_JERK_ACCEL: jerk_acc <= cfg_data;
          jlsp_pkg::CFG_ACCEL_LIM:  acc_lim  <= cfg_data;
          jlsp_pkg::CFG_JERK_DECEL: jerk_dec <= cfg_data;
          jlsp_pkg::CFG_DECEL_LIM:  dec_lim  <= cfg_data;
          jlsp_pkg::CFG_TICK_PER:   tick_per <= cfg_data[15:0];
          default: begin
          end
        endcase
      end

      // divide / root request bookkeeping
      if (ds_req.start)  issued <= 1'b1;
      else if (ds_done)  issued <= 1'b0;

      // result taken; a new one loaded in the final state overrides
      if (m_tvalid && m_tready && state != jlsp_pkg::ST_DONE) m_tvalid <= 1'b0;

      unique case (state)
        jlsp_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            tgt      <= $signed(s_tdata);
            res_jerk <= '0;
            priority if (s_tuser == jlsp_pkg::OP_TICK) res_status <= jlsp_pkg::STAT_TICK;
            else if ($signed(s_tdata) == last_target)  res_status <= jlsp_pkg::STAT_SAME;
            else if (accel_now != 32'sd0)              res_status <= jlsp_pkg::STAT_BUSY;
            else                                       res_status <= jlsp_pkg::STAT_TICK;
          end
        end
        jlsp_pkg::ST_TK_TIME: elapsed <= jlsp_pkg::tadd(elapsed, {48'd0, tick_per});
        jlsp_pkg::ST_TK_SEG: begin
          tk_t <= t_calc;
          tk_j <= seg_jerk[active];
          tk_a <= seg_accel[active];
          tk_v <= seg_speed[active];
          if (elapsed > seg_end[active] && active != 2'(jlsp_pkg::SEGMENTS - 1)) begin
            active <= active + 1'b1;
          end
        end
        jlsp_pkg::ST_TK_ACC: begin
          tk_da     <= da_c;
          tk_mag    <= mag_c[47:0];
          accel_now <= acc_c;
          res_jerk  <= tk_j;
        end
        jlsp_pkg::ST_TK_DV1: tk_dv1 <= dv1_c;
        jlsp_pkg::ST_TK_LO:  tk_lo  <= mul_p[55:0];
        jlsp_pkg::ST_TK_HI:  tk_dv2 <= dv2_c;
        jlsp_pkg::ST_TK_SPD: speed_now <= spd_c;
        jlsp_pkg::ST_P_DVJ: begin
          p_up <= up_c;
          p_dv <= dv_c;
          p_a  <= a_c;
          p_j  <= j_c;
        end
        jlsp_pkg::ST_P_AA: p_dvj <= mul_p[63:0];
        jlsp_pkg::ST_P_CMP: begin
          p_full <= full_c;
          if (full_c) p_pk <= {4'd0, p_a};
        end
        jlsp_pkg::ST_P_SQRT: if (ds_done) p_pk <= ds_result[27:0];
        jlsp_pkg::ST_P_TR: begin
          if (!issued) p_pp <= mul_p[63:0];
          if (ds_done) p_tr <= ds_result;
        end
        jlsp_pkg::ST_P_VADD: if (ds_done) p_vadd <= ds_result;
        jlsp_pkg::ST_P_MID:  if (ds_done) p_tmid <= ds_result;
        jlsp_pkg::ST_P_WRITE: begin
          seg_speed[0] <= speed_now;
          seg_accel[0] <= '0;
          seg_jerk[0]  <= sgnj;
          seg_start[0] <= elapsed;
          seg_end[0]   <= e0;
          seg_speed[1] <= jlsp_pkg::sat32(s1v);
          seg_accel[1] <= sgnpk;
          seg_jerk[1]  <= p_full ? 32'sd0 : nsgnj;
          seg_start[1] <= e0;
          seg_end[1]   <= e1;
          if (p_full) begin
            seg_speed[2] <= jlsp_pkg::sat32(s2v);
            seg_accel[2] <= sgnpk;
            seg_jerk[2]  <= nsgnj;
            seg_start[2] <= e1;
            seg_end[2]   <= e2;
            seg_start[3] <= e2;
            res_status   <= jlsp_pkg::STAT_FULL;
          end else begin
            seg_speed[2] <= tgt;
            seg_accel[2] <= '0;
            seg_jerk[2]  <= '0;
            seg_start[2] <= e1;
            seg_end[2]   <= jlsp_pkg::TIME_MAX;
            seg_start[3] <= e1;
            res_status   <= jlsp_pkg::STAT_REDUCED;
          end
          seg_speed[3] <= tgt;
          seg_accel[3] <= '0;
          seg_jerk[3]  <= '0;
          seg_end[3]   <= jlsp_pkg::TIME_MAX;
          last_target  <= tgt;
          active       <= '0;
          plan_valid   <= 1'b1;
        end
        jlsp_pkg::ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, active, res_jerk, accel_now, speed_now};
            m_tuser  <= res_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/jlsp_check.sv
// jlsp_check: port-level assertions for jerk_limited_speed_profile, bound to the top.
// Uses jlsp_pkg status codes.
module jlsp_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [2:0]   m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item at a time: busy right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= jlsp_pkg::STAT_SAME)
    else $error("bad status code");

  // target results carry no jerk
  a_tgt_jerk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != jlsp_pkg::STAT_TICK |-> m_tdata[95:64] == 32'd0)
    else $error("jerk on a target result");

  // a new plan starts in its first segment
  a_plan_seg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == jlsp_pkg::STAT_FULL || m_tuser == jlsp_pkg::STAT_REDUCED)
    |-> m_tdata[97:96] == 2'd0)
    else $error("new plan not in first segment");

endmodule

bind jerk_limited_speed_profile jlsp_check u_check (.*);
